@@ design/fwbo_pkg.sv @@
// ----------------------------------------------------------------------------
// fwbo_pkg: shared types and constants of the filter window box overlap block
// Payload structs, register indexes and fixed widths of the datapath.
// ----------------------------------------------------------------------------
package fwbo_pkg;

	localparam int FEATURE_DIM_MAX_DEF = 256;
	localparam int IMAGE_DIM_MAX_DEF   = 4096;

	localparam int BOX_W   = 13;
	localparam int SCALE_W = 16;
	localparam int CELL_W  = 8;
	localparam int GEO_W   = 32;
	localparam int CFG_IDX_W = 3;

	localparam int CRD_W = 28;
	localparam int EXT_W = 30;
	localparam int AREA_W = 30;
	localparam int WIDE_W = 64;
	localparam int Q_W = 16;

	localparam logic signed [CRD_W-1:0] ONE_PIX = CRD_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LEFT     = 3'd0,
		REG_BOX_TOP      = 3'd1,
		REG_BOX_RIGHT    = 3'd2,
		REG_BOX_BOTTOM   = 3'd3,
		REG_IMAGE_WIDTH  = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5,
		REG_PIXEL_SCALE  = 3'd6,
		REG_WINDOW_GEO   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_col;
		logic [CELL_W-1:0] cell_row;
	} in_t;

	typedef struct packed {
		logic [Q_W-1:0]    overlap_ratio;
		logic              has_intersection;
		logic [CELL_W-1:0] out_col;
		logic [CELL_W-1:0] out_row;
	} out_t;

	typedef struct packed {
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic              hit;
		logic              usable;
		logic              sat;
	} tag_t;

endpackage

@@ design/filter_window_box_overlap.sv @@
// ----------------------------------------------------------------------------
// filter_window_box_overlap: filter window versus box intersection over union
// Places a filter window at a feature cell and rates its overlap with a box.
// ----------------------------------------------------------------------------
// One cell is accepted every clock while the output is not stalled; seven
// geometry stages feed a sixteen-stage divider that yields one quotient bit per
// stage. A stall at the output holds the whole pipeline.
module filter_window_box_overlap
	import fwbo_pkg::*;
#(
	parameter int FEATURE_DIM_MAX = FEATURE_DIM_MAX_DEF,
	parameter int IMAGE_DIM_MAX   = IMAGE_DIM_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GEO_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data
);

	logic [BOX_W-1:0]   box_left_q, box_top_q, box_right_q, box_bottom_q;
	logic [BOX_W-1:0]   image_width_q, image_height_q;
	logic [SCALE_W-1:0] pixel_scale_q;
	logic [GEO_W-1:0]   window_geo_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q     <= BOX_W'(1);
			box_top_q      <= BOX_W'(1);
			box_right_q    <= BOX_W'(1);
			box_bottom_q   <= BOX_W'(1);
			image_width_q  <= BOX_W'(1);
			image_height_q <= BOX_W'(1);
			pixel_scale_q  <= SCALE_W'(256);
			window_geo_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_BOX_LEFT:     box_left_q     <= cfg_data[BOX_W-1:0];
				REG_BOX_TOP:      box_top_q      <= cfg_data[BOX_W-1:0];
				REG_BOX_RIGHT:    box_right_q    <= cfg_data[BOX_W-1:0];
				REG_BOX_BOTTOM:   box_bottom_q   <= cfg_data[BOX_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[BOX_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[BOX_W-1:0];
				REG_PIXEL_SCALE:  pixel_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_WINDOW_GEO:   window_geo_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CELL_W-1:0] fcols, frows, padx, pady;
	logic [BOX_W-1:0]  imw, imh;
	logic signed [CRD_W-1:0] bx1, by1, bx2, by2, xhi, yhi;

	assign fcols = window_geo_q[7:0];
	assign frows = window_geo_q[15:8];
	assign padx  = window_geo_q[23:16];
	assign pady  = window_geo_q[31:24];
	assign imw = (32'(image_width_q) > IMAGE_DIM_MAX) ? BOX_W'(IMAGE_DIM_MAX) : image_width_q;
	assign imh = (32'(image_height_q) > IMAGE_DIM_MAX) ? BOX_W'(IMAGE_DIM_MAX) : image_height_q;
	assign bx1 = ($signed(CRD_W'(box_left_q)) - CRD_W'(1)) <<< 8;
	assign by1 = ($signed(CRD_W'(box_top_q)) - CRD_W'(1)) <<< 8;
	assign bx2 = ($signed(CRD_W'(box_right_q)) - CRD_W'(1)) <<< 8;
	assign by2 = ($signed(CRD_W'(box_bottom_q)) - CRD_W'(1)) <<< 8;
	assign xhi = ($signed(CRD_W'(imw)) - CRD_W'(1)) <<< 8;
	assign yhi = ($signed(CRD_W'(imh)) - CRD_W'(1)) <<< 8;

	logic adv;
	logic div_vld;
	logic [Q_W-1:0] div_quo;
	tag_t div_tag;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: cell limits, window origin and extent products, areas.
	logic v_s1;
	logic [CELL_W-1:0] col_s1, row_s1;
	logic signed [CRD_W-1:0] x1_s1, y1_s1;
	logic [23:0] fws_s1, fhs_s1;
	logic signed [AREA_W-1:0] barea_s1;
	logic [2*BOX_W-1:0] imarea_s1;

	logic [CELL_W-1:0] col_l, row_l;
	logic signed [9:0] dx, dy;
	logic signed [14:0] bw, bh;
	assign col_l = (32'(in_data.cell_col) >= FEATURE_DIM_MAX) ?
		CELL_W'(FEATURE_DIM_MAX - 1) : in_data.cell_col;
	assign row_l = (32'(in_data.cell_row) >= FEATURE_DIM_MAX) ?
		CELL_W'(FEATURE_DIM_MAX - 1) : in_data.cell_row;
	assign dx = $signed({2'b0, col_l}) - $signed({2'b0, padx});
	assign dy = $signed({2'b0, row_l}) - $signed({2'b0, pady});
	assign bw = $signed({2'b0, box_right_q}) - $signed({2'b0, box_left_q}) + 15'sd1;
	assign bh = $signed({2'b0, box_bottom_q}) - $signed({2'b0, box_top_q}) + 15'sd1;

	// Stage 2: far window edges and the clip decision.
	logic v_s2;
	logic [CELL_W-1:0] col_s2, row_s2;
	logic signed [CRD_W-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	logic signed [AREA_W-1:0] barea_s2;
	logic clip_s2;

	logic signed [34:0] ba10, im7;
	assign ba10 = 35'(barea_s1) * 35'sd10;
	assign im7  = $signed({9'b0, imarea_s1}) * 35'sd7;

	// Stage 3: window, clamped to the image when the clip decision is set.
	logic v_s3;
	logic [CELL_W-1:0] col_s3, row_s3;
	logic signed [CRD_W-1:0] x1_s3, y1_s3, x2_s3, y2_s3;
	logic signed [AREA_W-1:0] barea_s3;

	function automatic logic signed [CRD_W-1:0] clamp_edge(
		input logic signed [CRD_W-1:0] v,
		input logic signed [CRD_W-1:0] hi
	);
		logic signed [CRD_W-1:0] lo;
		lo = (v > 0) ? v : '0;
		return (lo < hi) ? lo : hi;
	endfunction

	// Stage 4: intersection and window extents.
	logic v_s4;
	logic [CELL_W-1:0] col_s4, row_s4;
	logic signed [EXT_W-1:0] iw_s4, ih_s4, fw_s4, fh_s4;
	logic signed [AREA_W-1:0] barea_s4;
	logic hit_s4;

	logic signed [CRD_W-1:0] mnx, mxx, mny, mxy;
	logic signed [EXT_W-1:0] iw, ih;
	assign mnx = (x2_s3 < bx2) ? x2_s3 : bx2;
	assign mxx = (x1_s3 > bx1) ? x1_s3 : bx1;
	assign mny = (y2_s3 < by2) ? y2_s3 : by2;
	assign mxy = (y1_s3 > by1) ? y1_s3 : by1;
	assign iw = EXT_W'(mnx) - EXT_W'(mxx) + EXT_W'(ONE_PIX);
	assign ih = EXT_W'(mny) - EXT_W'(mxy) + EXT_W'(ONE_PIX);

	// Stage 5: areas.
	logic v_s5;
	logic [CELL_W-1:0] col_s5, row_s5;
	logic signed [WIDE_W-1:0] inter_s5, farea_s5;
	logic signed [AREA_W-1:0] barea_s5;
	logic hit_s5;

	// Stage 6: union.
	logic v_s6;
	logic [CELL_W-1:0] col_s6, row_s6;
	logic signed [WIDE_W-1:0] inter_s6, uni_s6;
	logic hit_s6;

	// Stage 7: divider operands and saturation flags.
	logic v_s7;
	logic [WIDE_W-1:0] rem_s7, den_s7;
	tag_t tag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1    <= in_data.cell_col;
			row_s1    <= in_data.cell_row;
			x1_s1     <= CRD_W'(dx * $signed({1'b0, pixel_scale_q}));
			y1_s1     <= CRD_W'(dy * $signed({1'b0, pixel_scale_q}));
			fws_s1    <= fcols * pixel_scale_q;
			fhs_s1    <= frows * pixel_scale_q;
			barea_s1  <= AREA_W'(bw * bh);
			imarea_s1 <= imw * imh;

			col_s2   <= col_s1;
			row_s2   <= row_s1;
			x1_s2    <= x1_s1;
			y1_s2    <= y1_s1;
			x2_s2    <= x1_s1 + $signed({4'b0, fws_s1}) - ONE_PIX;
			y2_s2    <= y1_s1 + $signed({4'b0, fhs_s1}) - ONE_PIX;
			barea_s2 <= barea_s1;
			clip_s2  <= ba10 < im7;

			col_s3   <= col_s2;
			row_s3   <= row_s2;
			x1_s3    <= clip_s2 ? clamp_edge(x1_s2, xhi) : x1_s2;
			y1_s3    <= clip_s2 ? clamp_edge(y1_s2, yhi) : y1_s2;
			x2_s3    <= clip_s2 ? clamp_edge(x2_s2, xhi) : x2_s2;
			y2_s3    <= clip_s2 ? clamp_edge(y2_s2, yhi) : y2_s2;
			barea_s3 <= barea_s2;

			col_s4   <= col_s3;
			row_s4   <= row_s3;
			iw_s4    <= iw;
			ih_s4    <= ih;
			fw_s4    <= EXT_W'(x2_s3) - EXT_W'(x1_s3) + EXT_W'(ONE_PIX);
			fh_s4    <= EXT_W'(y2_s3) - EXT_W'(y1_s3) + EXT_W'(ONE_PIX);
			barea_s4 <= barea_s3;
			hit_s4   <= (iw > 0) && (ih > 0);

			col_s5   <= col_s4;
			row_s5   <= row_s4;
			inter_s5 <= WIDE_W'(iw_s4 * ih_s4);
			farea_s5 <= WIDE_W'(fw_s4 * fh_s4);
			barea_s5 <= barea_s4;
			hit_s5   <= hit_s4;

			col_s6   <= col_s5;
			row_s6   <= row_s5;
			inter_s6 <= inter_s5;
			uni_s6   <= farea_s5 + (WIDE_W'(barea_s5) <<< 16) - inter_s5;
			hit_s6   <= hit_s5;

			rem_s7        <= inter_s6;
			den_s7        <= uni_s6;
			tag_s7.col    <= col_s6;
			tag_s7.row    <= row_s6;
			tag_s7.hit    <= hit_s6;
			tag_s7.usable <= hit_s6 && (uni_s6 > 0);
			tag_s7.sat    <= inter_s6 >= uni_s6;
		end
	end

	fwbo_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (v_s7),
		.in_rem  (rem_s7),
		.in_den  (den_s7),
		.in_tag  (tag_s7),
		.out_vld (div_vld),
		.out_quo (div_quo),
		.out_tag (div_tag)
	);

	assign out_valid = div_vld;
	assign out_data.overlap_ratio = !div_tag.usable ? '0 :
		(div_tag.sat ? '1 : div_quo);
	assign out_data.has_intersection = div_tag.hit;
	assign out_data.out_col = div_tag.col;
	assign out_data.out_row = div_tag.row;

endmodule

@@ design/fwbo_div_pipe.sv @@
// ----------------------------------------------------------------------------
// fwbo_div_pipe: pipelined restoring divider
// One quotient bit per stage; the caller must keep the remainder below the divisor, this block does not enforce it.
// ----------------------------------------------------------------------------
module fwbo_div_pipe
	import fwbo_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [WIDE_W-1:0] in_rem,
	input  logic [WIDE_W-1:0] in_den,
	input  tag_t              in_tag,
	output logic              out_vld,
	output logic [Q_W-1:0]    out_quo,
	output tag_t              out_tag
);

	logic              vld_s [Q_W+1];
	logic [WIDE_W-1:0] rem_s [Q_W+1];
	logic [WIDE_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]    quo_s [Q_W+1];
	tag_t              tag_s [Q_W+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = in_rem;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [WIDE_W-1:0] dbl;
		logic              ge;
		assign dbl = {rem_s[k][WIDE_W-2:0], 1'b0};
		assign ge  = dbl >= den_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? dbl - den_s[k] : dbl;
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][Q_W-2:0], ge};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign out_quo = quo_s[Q_W];
	assign out_tag = tag_s[Q_W];

endmodule
